/* design/ipct_pkg.sv */
// ----------------------------------------------------------------------------
// ipct_pkg
// Shared types and constants of the interval pair count table.
// ----------------------------------------------------------------------------
package ipct_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned COUNT_BITS    = 24;

  localparam int unsigned IDX_W      = $clog2(TABLE_ENTRIES);
  localparam int unsigned USED_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned COORD_W    = 31;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned OUT_CNT_W  = 24;
  localparam int unsigned OUT_USED_W = 9;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_DONE
  } back_state_e;

  // command handed from the front queue to the back end
  typedef struct packed {
    req_e               kind;
    logic               scan;
    logic [COORD_W-1:0] ibegin;
    logic [COORD_W-1:0] iend;
  } cmd_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0]  pair_count;
    logic                  pair_found;
    logic                  insert_dropped;
    logic [OUT_USED_W-1:0] entries_in_use;
  } res_t;

  typedef struct packed {
    logic [COORD_W-1:0]    ibegin;
    logic [COORD_W-1:0]    iend;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

endpackage

/* design/ipct_front.sv */
// ----------------------------------------------------------------------------
// ipct_front
// Accepts requests, decodes the request code and buffers them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module ipct_front import ipct_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [COORD_W-1:0] interval_begin_i,
  input  logic [COORD_W-1:0] interval_end_i,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  logic               cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.kind   = req_e'(req_type_i);
    cmd_new.scan   = (cmd_new.kind == REQ_INSERT) || (cmd_new.kind == REQ_QUERY);
    cmd_new.ibegin = interval_begin_i;
    cmd_new.iend   = interval_end_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= cmd_new;
  end

endmodule

/* design/ipct_back.sv */
// ----------------------------------------------------------------------------
// ipct_back
// Executes one command at a time: for an insert or query, scans the stored
// pairs one per cycle; then updates the table (insert, clear) and produces the result.
// ----------------------------------------------------------------------------
module ipct_back import ipct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_room_i,
  output logic res_valid_o,
  output res_t res_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [USED_W-1:0] scan_idx_q, scan_idx_d;
  logic              rvalid_q, rvalid_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;

  entry_t            mem_q [TABLE_ENTRIES];
  entry_t            rdata_q;
  logic              re, we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic              match;
  logic [COUNT_BITS-1:0] res_cnt;

  assign match = rvalid_q && (rdata_q.ibegin == cmd_q.ibegin)
               && (rdata_q.iend == cmd_q.iend);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    used_d     = used_q;
    scan_idx_d = scan_idx_q;
    rvalid_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_cnt_d  = hit_cnt_q;
    cmd_pop_o  = 1'b0;
    re         = 1'b0;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wdata      = '{ibegin: cmd_q.ibegin, iend: cmd_q.iend, cnt: '0};
    res_valid_o = 1'b0;
    res_cnt    = '0;
    res_o      = '0;

    case (state_q)
      BS_IDLE: begin
        // start only with room for the result, so BS_DONE never waits
        if (cmd_valid_i && res_room_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          scan_idx_d = '0;
          found_d    = 1'b0;
          state_d    = cmd_i.scan ? BS_SCAN : BS_DONE;
        end
      end

      BS_SCAN: begin
        if (match) begin
          found_d   = 1'b1;
          hit_idx_d = rd_idx_q;
          hit_cnt_d = rdata_q.cnt;
          state_d   = BS_DONE;
        end else if (scan_idx_q < used_q) begin
          re         = 1'b1;
          rvalid_d   = 1'b1;
          rd_idx_d   = scan_idx_q[IDX_W-1:0];
          scan_idx_d = scan_idx_q + USED_W'(1);
        end else begin
          state_d = BS_DONE;
        end
      end

      BS_DONE: begin
        res_valid_o = 1'b1;
        state_d     = BS_IDLE;
        case (cmd_q.kind)
          REQ_INSERT: begin
            if (found_q) begin
              res_cnt   = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q
                                                   : hit_cnt_q + COUNT_BITS'(1);
              we        = 1'b1;
              waddr     = hit_idx_q;
              wdata.cnt = res_cnt;
            end else if (used_q < USED_W'(TABLE_ENTRIES)) begin
              res_cnt   = COUNT_BITS'(1);
              we        = 1'b1;
              waddr     = used_q[IDX_W-1:0];
              wdata.cnt = res_cnt;
              used_d    = used_q + USED_W'(1);
            end else begin
              res_o.insert_dropped = 1'b1;
            end
            res_o.pair_found = found_q;
          end
          REQ_QUERY: begin
            res_cnt          = found_q ? hit_cnt_q : '0;
            res_o.pair_found = found_q;
          end
          REQ_CLEAR: begin
            used_d = '0;
          end
          default: begin
          end
        endcase
        res_o.pair_count     = OUT_CNT_W'(res_cnt);
        res_o.entries_in_use = OUT_USED_W'(used_d);
      end

      default: begin
        state_d = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BS_IDLE;
      used_q     <= '0;
      scan_idx_q <= '0;
      rvalid_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      scan_idx_q <= scan_idx_d;
      rvalid_q   <= rvalid_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_cnt_q <= hit_cnt_d;
  end

  // table storage, one port: reads only while scanning, writes only in BS_DONE
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[rd_idx_d];
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_read_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> (scan_idx_q < used_q) && (state_q == BS_SCAN))
    else $error("read of an entry not in use");

  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_room_i)
    else $error("result produced without queue room");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == BS_IDLE) && !res_valid_o)
    else $error("more than one result per command");

  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(re && we))
    else $error("read and write in the same cycle");

endmodule

/* design/interval_pair_count_table.sv */
// ----------------------------------------------------------------------------
// interval_pair_count_table
// Counts occurrences of distinct (begin, end) interval pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: a transaction is taken at a
//   rising edge with push high and full low. req_type selects insert, query
//   or clear; code 3 is a no-op that only reports the entry count.
//   Results leave through a queue-style port: the oldest result sits on the
//   result ports while empty is low and is taken at an edge with pop high.
//   Exactly one result is returned per request, in request order.
// Execution:
//   An insert or query scans the stored pairs, one table read per cycle on
//   the single memory port, and stops at the first match. Clear and no-op
//   skip the scan. One request is executed at a time.
// Reset and stall:
//   Reset empties the table (entry count to zero) and both queues; no
//   clearing pass is needed. A two-entry request queue keeps taking requests
//   while a result waits; if the result queue fills, execution pauses and
//   full rises once the request queue is full too.
// ----------------------------------------------------------------------------
module interval_pair_count_table import ipct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [COORD_W-1:0]    interval_begin_i,
  input  logic [COORD_W-1:0]    interval_end_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [OUT_CNT_W-1:0]  pair_count_o,
  output logic                  pair_found_o,
  output logic                  insert_dropped_o,
  output logic [OUT_USED_W-1:0] entries_in_use_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  logic res_room, res_valid;
  res_t res;

  res_t       res_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;
  res_t       head;

  ipct_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .req_type_i       (req_type_i),
    .interval_begin_i (interval_begin_i),
    .interval_end_i   (interval_end_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  ipct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_room_i  (res_room),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue
  assign res_room = (cnt_q != 2'd2);
  assign empty    = (cnt_q == 2'd0);
  assign do_pop   = pop && !empty;
  assign head     = res_q[rd_ptr_q];

  assign pair_count_o     = head.pair_count;
  assign pair_found_o     = head.pair_found;
  assign insert_dropped_o = head.insert_dropped;
  assign entries_in_use_o = head.entries_in_use;

  always_comb begin
    cnt_d = cnt_q;
    if (res_valid && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!res_valid && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (res_valid) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)    rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) res_q[wr_ptr_q] <= res;
  end

endmodule
